FILE: rtl/rcmp_pkg.sv
// Shared constants and types for the rod cutting maximum profit block.
`timescale 1ns / 1ps
`default_nettype none

package rcmp_pkg;

  localparam int PRICE_W    = 16;
  localparam int PROFIT_W   = 21;
  localparam int LEN_W      = 7;
  localparam int PRICE_PEAK = 32767;

  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  typedef struct packed {
    logic clear;
    logic take;
  } acc_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/rod_cutting_max_profit.sv
// Top level of the rod cutting maximum profit block: price loading, table fill sequencer, result.
`timescale 1ns / 1ps
`default_nettype none

// Prices arrive one per cycle, the price of length 1 first; the transaction with last set
// closes the list and the rod length n is the number of prices kept (at most MAX_LEN, extras
// are dropped and flagged). After the last price the input stalls while the best-profit table
// is filled by one shared add and compare unit reading one price and one table entry per
// cycle, and the result is then handed to the output register. The output register holds
// the result while the next list loads; a new fill does not finish until the previous
// result has been taken.
module rod_cutting_max_profit
  import rcmp_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [PRICE_W-1:0]  price,
  input  wire logic                last,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [PROFIT_W-1:0] profit,
  output logic      [LEN_W-1:0]    rod_length,
  output logic                     overflow
);

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int BW  = $clog2(MAX_LEN * PRICE_PEAK + 1);
  localparam int SW  = (BW > PROFIT_W) ? BW : PROFIT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic                dropped;
  logic [CW-1:0]       row;
  logic [CW-1:0]       col;
  logic                pend;
  logic [PROFIT_W-1:0] fin_profit;

  logic                in_accept;
  logic                out_free;
  logic                price_we;
  logic [PRICE_W-1:0]  price_rdata;
  logic                best_we;
  logic [CW-1:0]       best_waddr;
  logic [BW-1:0]       best_wdata;
  logic [CW-1:0]       best_raddr;
  logic [BW-1:0]       best_rdata;
  logic [BW-1:0]       unit_result;
  logic [SW-1:0]       result_wide;
  acc_ctrl_t           ctrl;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign price_we   = in_accept && (count < CW'(MAX_LEN));
  assign best_raddr = CW'(row - CW'(1) - col);
  assign result_wide = SW'(unit_result);

  always_comb begin
    ctrl.clear = (state == S_INIT) || (state == S_WRITE);
    ctrl.take  = ((state == S_RUN) && pend) || (state == S_WRITE);
    best_we    = (state == S_INIT) || (state == S_WRITE);
    if (state == S_INIT) begin
      best_waddr = '0;
      best_wdata = '0;
    end else begin
      best_waddr = row;
      best_wdata = unit_result;
    end
  end

  rcmp_ram #(
    .WIDTH(PRICE_W),
    .DEPTH(MAX_LEN)
  ) u_price_ram (
    .clk  (clk),
    .we   (price_we),
    .waddr(count[AW-1:0]),
    .wdata(price),
    .raddr(col[AW-1:0]),
    .rdata(price_rdata)
  );

  rcmp_ram #(
    .WIDTH(BW),
    .DEPTH(MAX_LEN + 1)
  ) u_best_ram (
    .clk  (clk),
    .we   (best_we),
    .waddr(best_waddr),
    .wdata(best_wdata),
    .raddr(best_raddr),
    .rdata(best_rdata)
  );

  rcmp_max_unit #(
    .BW(BW)
  ) u_max_unit (
    .clk   (clk),
    .ctrl  (ctrl),
    .price (price_rdata),
    .best  (best_rdata),
    .result(unit_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      row       <= '0;
      col       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (price_we) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          row   <= CW'(1);
          col   <= '0;
          pend  <= 1'b0;
          state <= S_RUN;
        end
        S_RUN: begin
          pend <= 1'b1;
          col  <= col + CW'(1);
          if (col == CW'(row - CW'(1))) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          pend <= 1'b0;
          col  <= '0;
          if (row == count) begin
            if (result_wide > SW'(PROFIT_MAX)) begin
              fin_profit <= PROFIT_MAX;
            end else begin
              fin_profit <= PROFIT_W'(result_wide);
            end
            state <= S_FINISH;
          end else begin
            row   <= row + CW'(1);
            state <= S_RUN;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            count     <= '0;
            dropped   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      profit     <= fin_profit;
      rod_length <= LEN_W'(count);
      overflow   <= dropped;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rcmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rcmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/rcmp_max_unit.sv
// Shared add and compare unit that keeps the running best candidate of one table row.
`timescale 1ns / 1ps
`default_nettype none

module rcmp_max_unit
  import rcmp_pkg::*;
#(
  parameter int BW = 22
) (
  input  wire logic                clk,
  input  wire acc_ctrl_t           ctrl,
  input  wire logic [PRICE_W-1:0]  price,
  input  wire logic [BW-1:0]       best,
  output logic      [BW-1:0]       result
);

  logic        [BW-1:0] acc;
  logic signed [BW:0]   price_ext;
  logic signed [BW:0]   best_ext;
  logic signed [BW:0]   cand;
  logic signed [BW:0]   acc_ext;

  assign price_ext = (BW + 1)'($signed(price));
  assign best_ext  = signed'((BW + 1)'(best));
  assign acc_ext   = signed'((BW + 1)'(acc));
  assign cand      = price_ext + best_ext;

  always_comb begin
    if (ctrl.take && (cand > acc_ext)) begin
      result = BW'(cand);
    end else begin
      result = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.take) begin
      acc <= result;
    end
  end

endmodule

`default_nettype wire

FILE: verif/rod_cutting_max_profit_test.sv
// Testbench for the rod cutting maximum profit block: random price lists checked against a predictor.
`timescale 1ns / 1ps

module rod_cutting_max_profit_test;
  import rcmp_pkg::*;

  localparam int ROD_MAX = 64;
  localparam int ITEM_TARGET = 1350;
  localparam int LONG_HOLD = 500;
  localparam int FILL_CYCLES_MAX = 1 + ROD_MAX * (ROD_MAX + 3) / 2 + 4;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum {
    MIX_ANY,
    MIX_GROWING,
    MIX_NEGATIVE,
    MIX_EDGE,
    MIX_NEAR_ZERO,
    MIX_TOP
  } price_mix_t;

  typedef struct {
    logic [PRICE_W-1:0] price;
    logic               last;
    bit                 pause;
  } price_item_t;

  typedef struct {
    logic [PROFIT_W-1:0] profit;
    logic [LEN_W-1:0]    length;
    logic                ovf;
  } rod_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PRICE_W-1:0]  price = '0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PROFIT_W-1:0] profit;
  logic [LEN_W-1:0]    rod_length;
  logic                overflow;

  price_item_t pending_q[$];
  rod_result_t rod_result_q[$];

  logic signed [PRICE_W-1:0] rod_prices [ROD_MAX];
  int unsigned rod_count = 0;
  bit          rod_dropped = 1'b0;

  int n_predicted = 0;
  int n_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  rod_cutting_max_profit #(.MAX_LEN(ROD_MAX)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .price      (price),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .profit     (profit),
    .rod_length (rod_length),
    .overflow   (overflow)
  );

  always #4 clk = ~clk;

  function automatic int pick_idle();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [PRICE_W-1:0] draw_price(price_mix_t mix, int unsigned pos);
    logic [PRICE_W-1:0] edges [5];
    edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    case (mix)
      MIX_GROWING: begin
        return PRICE_W'(pos * $urandom_range(1, 400));
      end
      MIX_NEGATIVE: begin
        return PRICE_W'(-$urandom_range(1, 32768));
      end
      MIX_EDGE: begin
        return edges[$urandom_range(0, 4)];
      end
      MIX_NEAR_ZERO: begin
        return PRICE_W'($urandom_range(0, 40) - 20);
      end
      MIX_TOP: begin
        return PRICE_W'(PRICE_PEAK);
      end
      default: begin
        return PRICE_W'($urandom);
      end
    endcase
  endfunction

  function automatic void push_price(logic [PRICE_W-1:0] p, logic is_last, bit pause);
    price_item_t item;
    item.price = p;
    item.last = is_last;
    item.pause = pause;
    pending_q.push_back(item);
  endfunction

  function automatic void add_rod(int n, price_mix_t mix, bit pause);
    for (int k = 1; k <= n; k++) begin
      push_price(draw_price(mix, k), k == n, pause && k == 1);
    end
  endfunction

  // Bottom-up best profit over all cuttings of a rod of length n, floored at zero.
  function automatic logic [PROFIT_W-1:0] best_profit(int unsigned n);
    longint best_len [ROD_MAX+1];
    longint top;
    longint cand;
    best_len[0] = 0;
    for (int unsigned i = 1; i <= n; i++) begin
      top = 0;
      for (int unsigned j = 0; j < i; j++) begin
        cand = longint'(rod_prices[j]) + best_len[i-1-j];
        if (cand > top) begin
          top = cand;
        end
      end
      best_len[i] = top;
    end
    if (best_len[n] > longint'(PROFIT_MAX)) begin
      return PROFIT_MAX;
    end
    return PROFIT_W'(best_len[n]);
  endfunction

  function automatic void take_price(logic [PRICE_W-1:0] p, logic is_last);
    rod_result_t want;
    if (rod_count < ROD_MAX) begin
      rod_prices[rod_count] = p;
      rod_count++;
    end else begin
      rod_dropped = 1'b1;
    end
    if (is_last) begin
      want.profit = best_profit(rod_count);
      want.length = LEN_W'(rod_count);
      want.ovf = rod_dropped;
      rod_result_q.push_back(want);
      n_predicted++;
      rod_count = 0;
      rod_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : driver
    price_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) begin
        send_quiet <= !send_quiet;
      end
      if (in_valid && !in_stall) begin
        take_price(price, last);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     (!pending_q[0].pause || n_checked == n_predicted)) begin
          item = pending_q.pop_front();
          in_valid <= 1'b1;
          price <= item.price;
          last <= item.last;
          send_gap <= (send_quiet || $urandom_range(0, 99) < 60) ? 0 : pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) begin
        recv_quiet <= !recv_quiet;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_checked == 12) begin
        // Hold the output long enough for the block to back up into its input.
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!recv_quiet && $urandom_range(0, 99) < 25) begin
        stall_left <= pick_idle() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    rod_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rod_result_q.size() == 0) begin
        $display("%0t: unexpected result profit=%0d length=%0d overflow=%0b",
                 $time, profit, rod_length, overflow);
        error_count++;
      end else begin
        want = rod_result_q.pop_front();
        n_checked <= n_checked + 1;
        if (profit !== want.profit) begin
          $display("%0t: profit expected %0d actual %0d", $time, want.profit, profit);
          error_count++;
        end
        if (rod_length !== want.length) begin
          $display("%0t: rod_length expected %0d actual %0d", $time, want.length, rod_length);
          error_count++;
        end
        if (overflow !== want.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, overflow);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int n;
    int pick;
    int rods;
    price_mix_t mix;

    // Single-piece rods at both price extremes.
    push_price(16'h7FFF, 1'b1, 1'b0);
    push_price(16'h8000, 1'b1, 1'b0);
    // Every candidate negative, so the zero floor wins.
    push_price(16'hFFFF, 1'b0, 1'b0);
    push_price(16'h8000, 1'b0, 1'b0);
    push_price(16'hFFFB, 1'b1, 1'b0);
    // Textbook price list; the sender first waits for all results.
    push_price(16'd1, 1'b0, 1'b1);
    push_price(16'd5, 1'b0, 1'b0);
    push_price(16'd8, 1'b0, 1'b0);
    push_price(16'd9, 1'b1, 1'b0);
    push_price(16'd0, 1'b0, 1'b0);
    push_price(16'd0, 1'b1, 1'b0);
    push_price(16'h8000, 1'b0, 1'b0);
    push_price(16'h7FFF, 1'b0, 1'b0);
    push_price(16'hFFFF, 1'b1, 1'b0);
    push_price(16'd10, 1'b0, 1'b0);
    push_price(16'hFFFD, 1'b1, 1'b0);

    // Largest possible total, then a list that runs past the table size.
    add_rod(ROD_MAX, MIX_TOP, 1'b0);
    add_rod(ROD_MAX + 3, MIX_ANY, 1'b0);

    rods = 0;
    while (pending_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        n = $urandom_range(1, 12);
      end else if (pick < 93) begin
        n = $urandom_range(13, 40);
      end else if (pick < 97) begin
        n = ROD_MAX;
      end else begin
        n = $urandom_range(ROD_MAX + 1, ROD_MAX + 8);
      end
      mix = price_mix_t'($urandom_range(0, 4));
      add_rod(n, mix, rods > 30 && $urandom_range(0, 39) == 0);
      rods++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (n_checked != n_predicted) begin
      @(posedge clk);
    end
    repeat (FILL_CYCLES_MAX) @(posedge clk);

    if (error_count == 0 && rod_result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
